FILE: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes of the sorted list engine
// Operation and status codes, the cell command and the sequencer states.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] key;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_READ
   } sle_state_type;

endpackage

FILE: design/sle_channels.sv
// ----------------------------------------------------------------------------
// sle_channels: request and response channels of the sorted list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sle_req_if;
   import sle_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                func;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, func, value, input ready);
   modport sink   (input valid, func, value, output ready);
endinterface

interface sle_rsp_if;
   import sle_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] entry_value;
   logic                      last;
   logic [1:0]                status;
   logic [COUNT_W-1:0]        entry_count;
   logic [COUNT_W-1:0]        removed_count;

   modport source (output valid, entry_value, last, status, entry_count, removed_count,
                   input ready);
   modport sink   (input valid, entry_value, last, status, entry_count, removed_count,
                   output ready);
endinterface

FILE: design/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one value and trades it with its neighbors for insert, shift and rotate.
// ----------------------------------------------------------------------------
module sle_cell #(
   parameter int IDX   = 0,
   parameter int OCC_W = 5
) (
   input  logic                               clock,
   input  sle_pkg::cell_cmd_type              cmd,
   input  logic [OCC_W-1:0]                   occ,
   input  logic signed [sle_pkg::VALUE_W-1:0] left_value,
   input  logic                               left_after,
   input  logic signed [sle_pkg::VALUE_W-1:0] right_value,
   input  logic signed [sle_pkg::VALUE_W-1:0] head_value,
   output logic signed [sle_pkg::VALUE_W-1:0] value,
   output logic                               after,
   output logic                               eq
);
   import sle_pkg::*;

   localparam logic [OCC_W-1:0] IDX_W  = OCC_W'(IDX);
   localparam logic [OCC_W-1:0] IDX1_W = OCC_W'(IDX + 1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      in_list;
   logic                      ge;

   assign in_list = IDX_W < occ;
   // slot lies at or past the insert point: empty, or holds a larger value
   assign after   = !in_list || (value_ff > cmd.key);
   assign ge      = !(cmd.key > value_ff);
   assign eq      = in_list && (value_ff == cmd.key);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (left_after) begin
               value_in = left_value;
            end else if (after) begin
               value_in = cmd.key;
            end
         end
         CELL_SHIFT: begin
            // matches are contiguous, so everything from the first match moves down
            if (in_list && ge) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (IDX1_W < occ) begin
               value_in = right_value;
            end else if (IDX1_W == occ) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: design/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine: sorted list of signed values in a row of cells
// Insert after equals, remove all equal, read out in order, clear.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                            | item
//  req_if   | in  | func, value                                        | one operation
//  rsp_if   | out | entry_value, last, status, entry_count, removed... | one result
//
//  Insert and clear are answered on acceptance; remove accepts, shifts out
//  each matching entry, then gives its result; read accepts, then returns
//  one entry per step (an empty list is answered on acceptance). The cell
//  row moves by one position per cycle; a held response pauses a read.
//  Synchronous active-high reset empties the list; no clearing pass.
//  A stalled response holds the engine; a new item is taken while the
//  previous result is being handed over.
module sorted_list_engine #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   sle_req_if.sink    req_if,
   sle_rsp_if.source  rsp_if
);
   import sle_pkg::*;

   localparam int               OCC_W = $clog2(CAPACITY + 1);
   localparam logic [OCC_W-1:0] CAP_W = OCC_W'(CAPACITY);
   localparam logic [OCC_W-1:0] ONE_W = OCC_W'(1);

   sle_state_type             state_ff, state_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic [OCC_W-1:0]          rm_ff, rm_in;
   logic [OCC_W-1:0]          rd_ff, rd_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;
   logic [1:0]                rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic [COUNT_W-1:0]        rsp_removed_ff;

   logic                      load;
   logic signed [VALUE_W-1:0] ld_value;
   logic                      ld_last;
   logic [1:0]                ld_status;
   logic [OCC_W-1:0]          ld_count;
   logic [OCC_W-1:0]          ld_removed;
   logic [OCC_W+COUNT_W-1:0]  count_wide;
   logic [OCC_W+COUNT_W-1:0]  removed_wide;

   cell_cmd_type              cmd;
   logic                      slot_free;
   logic                      any_eq;

   logic signed [VALUE_W-1:0] cell_val   [CAPACITY];
   logic signed [VALUE_W-1:0] left_val   [CAPACITY];
   logic signed [VALUE_W-1:0] right_val  [CAPACITY];
   logic                      left_aft   [CAPACITY];
   logic [CAPACITY-1:0]       cell_after;
   logic [CAPACITY-1:0]       cell_eq;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_val[gi] = cell_val[gi];
            assign left_aft[gi] = 1'b0;
         end else begin : g_mid
            assign left_val[gi] = cell_val[gi-1];
            assign left_aft[gi] = cell_after[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_val[gi] = cell_val[gi];
         end else begin : g_body
            assign right_val[gi] = cell_val[gi+1];
         end

         sle_cell #(
            .IDX   (gi),
            .OCC_W (OCC_W)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occ         (occ_ff),
            .left_value  (left_val[gi]),
            .left_after  (left_aft[gi]),
            .right_value (right_val[gi]),
            .head_value  (cell_val[0]),
            .value       (cell_val[gi]),
            .after       (cell_after[gi]),
            .eq          (cell_eq[gi])
         );
      end
   endgenerate

   assign any_eq    = |cell_eq;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      rm_in        = rm_ff;
      rd_in        = rd_ff;
      key_in       = key_ff;
      cmd.op       = CELL_HOLD;
      cmd.key      = key_ff;
      req_if.ready = 1'b0;
      load         = 1'b0;
      ld_value     = '0;
      ld_last      = 1'b1;
      ld_status    = STATUS_OK;
      ld_count     = occ_ff;
      ld_removed   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = slot_free;
            cmd.key      = req_if.value;
            if (req_if.valid && slot_free) begin
               case (req_if.func)
                  FUNC_INSERT: begin
                     load = 1'b1;
                     if (occ_ff == CAP_W) begin
                        ld_status = STATUS_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        occ_in   = occ_ff + ONE_W;
                        ld_count = occ_in;
                     end
                  end
                  FUNC_REMOVE: begin
                     key_in   = req_if.value;
                     rm_in    = '0;
                     state_in = ST_REMOVE;
                  end
                  FUNC_READ: begin
                     if (occ_ff == '0) begin
                        load      = 1'b1;
                        ld_status = STATUS_EMPTY;
                     end else begin
                        rd_in    = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     load     = 1'b1;
                     occ_in   = '0;
                     ld_count = '0;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            // one matching entry leaves per cycle until none is left
            if (any_eq) begin
               cmd.op = CELL_SHIFT;
               occ_in = occ_ff - ONE_W;
               rm_in  = rm_ff + ONE_W;
            end else if (slot_free) begin
               load       = 1'b1;
               ld_removed = rm_ff;
               state_in   = ST_IDLE;
            end
         end
         ST_READ: begin
            // the row rotates by one; after occ steps it is back in place
            if (slot_free) begin
               cmd.op   = CELL_ROTATE;
               load     = 1'b1;
               ld_value = cell_val[0];
               ld_last  = (rd_ff == occ_ff - ONE_W);
               rd_in    = rd_ff + ONE_W;
               if (ld_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_wide   = {{COUNT_W{1'b0}}, ld_count};
   assign removed_wide = {{COUNT_W{1'b0}}, ld_removed};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      rm_ff  <= rm_in;
      rd_ff  <= rd_in;
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_value_ff   <= ld_value;
         rsp_last_ff    <= ld_last;
         rsp_status_ff  <= ld_status;
         rsp_count_ff   <= count_wide[COUNT_W-1:0];
         rsp_removed_ff <= removed_wide[COUNT_W-1:0];
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.entry_value   = rsp_value_ff;
   assign rsp_if.last          = rsp_last_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.entry_count   = rsp_count_ff;
   assign rsp_if.removed_count = rsp_removed_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_W)
      else $error("occupancy above capacity");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> occ_ff != '0)
      else $error("read out of an empty list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.func == FUNC_INSERT && occ_ff != CAP_W
      |=> occ_ff == $past(occ_ff) + ONE_W)
      else $error("insert did not add an entry");

endmodule
